// File: sv/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int SIZE_WIDTH_DEF = 16;

  localparam int FUNC_W   = 1;
  localparam int SLOT_W   = 4;
  localparam int AMOUNT_W = 16;
  localparam int INDEX_W  = 4;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b1;

  // Classification of one queued word.
  typedef struct packed {
    logic is_req;
    logic slot_ok;
  } cmd_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

endpackage
`default_nettype wire

// File: sv/ffba_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`default_nettype none
module ffba_front #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_ready,
  input  wire  [ffba_pkg::FUNC_W-1:0]   in_func,
  input  wire  [ffba_pkg::SLOT_W-1:0]   in_slot,
  input  wire  [ffba_pkg::AMOUNT_W-1:0] in_amount,
  output logic                          q_valid,
  input  wire                           q_pop,
  output ffba_pkg::cmd_ctl_t            q_ctl,
  output logic [IDX_W-1:0]              q_idx,
  output logic [SIZE_WIDTH-1:0]         q_amount
);
  import ffba_pkg::*;

  cmd_ctl_t              ctl_q_r    [2];
  logic [IDX_W-1:0]      idx_q_r    [2];
  logic [SIZE_WIDTH-1:0] amount_q_r [2];
  logic                  wr_ptr_r;
  logic                  rd_ptr_r;
  logic [1:0]            count_r;
  logic [1:0]            count_nxt;
  logic                  push;
  cmd_ctl_t              in_ctl;

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign push     = in_valid && in_ready;

  always_comb begin
    in_ctl.is_req  = (in_func == FUNC_ALLOC);
    in_ctl.slot_ok = (32'(in_slot) < NUM_BLOCKS);
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Mask the amount to the table's size width before it is queued.
  always_ff @(posedge clk) begin
    if (push) begin
      ctl_q_r[wr_ptr_r]    <= in_ctl;
      idx_q_r[wr_ptr_r]    <= IDX_W'(in_slot);
      amount_q_r[wr_ptr_r] <= SIZE_WIDTH'(in_amount);
    end
  end

  assign q_ctl    = ctl_q_r[rd_ptr_r];
  assign q_idx    = idx_q_r[rd_ptr_r];
  assign q_amount = amount_q_r[rd_ptr_r];

endmodule
`default_nettype wire

// File: sv/ffba_back.sv
// Back end: block table, first-fit scan and result register.
`default_nettype none
module ffba_back #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16,
  parameter int IDX_W      = 4
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_valid,
  output logic                         q_pop,
  input  ffba_pkg::cmd_ctl_t           q_ctl,
  input  wire  [IDX_W-1:0]             q_idx,
  input  wire  [SIZE_WIDTH-1:0]        q_amount,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output logic [ffba_pkg::INDEX_W-1:0] out_block_index
);
  import ffba_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  logic [SIZE_WIDTH-1:0] size_mem [NUM_BLOCKS];
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  mem_we;

  back_state_t           state_r;
  back_state_t           state_nxt;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [SIZE_WIDTH-1:0] req_amount_r;
  logic                  res_found_r;
  logic [IDX_W-1:0]      res_idx_r;
  logic [NUM_BLOCKS-1:0] loaded_r;
  logic [NUM_BLOCKS-1:0] used_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [INDEX_W-1:0]    out_index_r;

  logic [SIZE_WIDTH-1:0] size_cur;
  logic                  hit;
  logic                  last;
  logic                  out_free;

  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign mem_we   = q_pop && !q_ctl.is_req && q_ctl.slot_ok;
  assign last     = (cmp_idx_r == LAST_IDX);
  // A block never loaded reads as size zero.
  assign size_cur = loaded_r[cmp_idx_r] ? rd_data_r : '0;
  assign hit      = !used_r[cmp_idx_r] && (size_cur >= req_amount_r);
  assign out_free = !out_valid_r || out_ready;

  // Prefetch the next block so its size is registered by the compare cycle.
  always_comb begin
    if (state_r == ST_SCAN && !last) begin
      rd_addr = cmp_idx_r + IDX_W'(1);
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[q_idx] <= q_amount;
    end
    rd_data_r <= size_mem[rd_addr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_ctl.is_req ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (hit || last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mem_we) begin
        loaded_r[q_idx] <= 1'b1;
        used_r[q_idx]   <= 1'b0;
      end
      if (state_r == ST_SCAN && hit) begin
        used_r[cmp_idx_r] <= 1'b1;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        cmp_idx_r    <= '0;
        req_amount_r <= q_amount;
        res_found_r  <= 1'b0;
        res_idx_r    <= '0;
      end
      ST_SCAN: begin
        if (hit) begin
          res_found_r <= 1'b1;
          res_idx_r   <= cmp_idx_r;
        end else if (!last) begin
          cmp_idx_r <= cmp_idx_r + IDX_W'(1);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_found_r <= res_found_r;
          out_index_r <= INDEX_W'(res_idx_r);
        end
      end
      default: begin
        cmp_idx_r <= '0;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_block_index = out_index_r;

endmodule
`default_nettype wire

// File: sv/first_fit_block_allocator_top.sv
// Top level of the first-fit block allocator: front queue and back-end table scan.
// A load word is written to the size table when the back end takes it, and the
// result is then registered; a request scans from block 0 until one fits or the
// last block is checked. One word is in the back end at a time, so it takes no
// new word until its result is registered; the scan checks one block per cycle.
// The front queue holds two more words while the back end scans.
// Reset clears the used and loaded bits at once; no clearing pass is needed.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
  parameter int SIZE_WIDTH = ffba_pkg::SIZE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  [ffba_pkg::FUNC_W-1:0]   in_func,
  input  wire  [ffba_pkg::SLOT_W-1:0]   in_slot,
  input  wire  [ffba_pkg::AMOUNT_W-1:0] in_amount,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic                         out_found,
  output logic [ffba_pkg::INDEX_W-1:0] out_block_index
);
  import ffba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic                  q_valid;
  logic                  q_pop;
  cmd_ctl_t              q_ctl;
  logic [IDX_W-1:0]      q_idx;
  logic [SIZE_WIDTH-1:0] q_amount;

  ffba_front #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_slot   (in_slot),
    .in_amount (in_amount),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_ctl     (q_ctl),
    .q_idx     (q_idx),
    .q_amount  (q_amount)
  );

  ffba_back #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_ctl           (q_ctl),
    .q_idx           (q_idx),
    .q_amount        (q_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_block_index (out_block_index)
  );

endmodule
`default_nettype wire
